@@ src/kalman_filter_pos_vel_3axis_core_defines.svh @@
// Assertion macros for the three-axis Kalman filter core.
`ifndef KALMAN_FILTER_POS_VEL_3AXIS_CORE_DEFINES_SVH
`define KALMAN_FILTER_POS_VEL_3AXIS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define KFPV_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kfpv assertion failed");
`define KFPV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kfpv assertion failed");
`else
`define KFPV_ASSERT_IMPLY(label, ante, cons)
`define KFPV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/kfpv_pkg.sv @@
// Package: types, constants and microcode for the Kalman filter core.
`default_nettype none
package kfpv_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int AXES       = 3;
    localparam int AXIS_W     = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int DATA_W     = 32;
    localparam int NREG       = 8;
    localparam int REG_IDX_W  = 3;
    localparam int PADDR_W    = REG_IDX_W + 2;
    localparam int NFIELD     = 10;
    localparam int FIELD_W    = 4;
    localparam int MEM_DEPTH  = NFIELD << AXIS_W;
    localparam int MEM_ADDR_W = FIELD_W + AXIS_W;
    localparam int NSLOT      = 16;
    localparam int SLOT_W     = 4;
    localparam int SRC_W      = 5;
    localparam int PC_W       = 5;
    localparam int DIVD_W     = DATA_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVD_W);

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t Q_MAX     = q_t'(32'sh7FFF_FFFF);
    localparam q_t Q_MIN     = q_t'(32'sh8000_0000);
    localparam q_t Q_ZERO    = q_t'(0);
    localparam q_t Q_ONE     = q_t'(1 << FRAC_BITS);
    localparam q_t Q_HALF    = q_t'(1 << (FRAC_BITS - 1));
    localparam q_t Q_QUARTER = q_t'(1 << (FRAC_BITS - 2));
    localparam logic [DATA_W-1:0] REG_RESET = 32'd65536;

    localparam logic [REG_IDX_W-1:0] REG_Q0       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_R0       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INIT_POS = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INIT_VEL = 3'd7;

    typedef enum logic [1:0] {
        OPC_PREDICT = 2'd0,
        OPC_UPDATE  = 2'd1,
        OPC_SKIP    = 2'd2,
        OPC_NOP     = 2'd3
    } opcode_t;

    typedef enum logic [FIELD_W-1:0] {
        F_POS, F_VEL, F_PPOS, F_PVEL, F_CPOS, F_CCRS, F_CVEL, F_PCPOS, F_PCCRS, F_PCVEL
    } field_t;

    // operand codes: slots 0..15 (state fields then temps), then inputs and constants
    typedef enum logic [SRC_W-1:0] {
        SRC_POS, SRC_VEL, SRC_PPOS, SRC_PVEL, SRC_CPOS, SRC_CCRS, SRC_CVEL,
        SRC_PCPOS, SRC_PCCRS, SRC_PCVEL,
        SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5,
        SRC_TIME, SRC_ACC, SRC_MEAS, SRC_QN, SRC_RN,
        SRC_ONE, SRC_HALF, SRC_QUARTER, SRC_ZERO
    } src_t;

    typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_op_t;

    typedef struct packed {
        alu_op_t op;
        src_t    dst;
        src_t    a;
        src_t    b;
    } uop_t;

    typedef struct packed {
        logic pos_var;
        logic vel_var;
    } cfg_evt_t;

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_LOAD, SEQ_OPRD, SEQ_ISSUE, SEQ_WAIT, SEQ_WB, SEQ_DONE
    } seq_state_t;

    typedef enum logic [1:0] {A_IDLE, A_MULRND, A_DIVRUN, A_DIVFIN} alu_state_t;

    function automatic q_t clamp_u(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? Q_MAX : q_t'(v);
    endfunction

    function automatic uop_t mk(input alu_op_t op, input src_t d, input src_t a, input src_t b);
        return uop_t'{op, d, a, b};
    endfunction

    function automatic uop_t predict_uop(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:    u = mk(ALU_MUL, SRC_T0, SRC_TIME, SRC_TIME);   // t2
            5'd1:    u = mk(ALU_MUL, SRC_T1, SRC_T0, SRC_TIME);     // t3
            5'd2:    u = mk(ALU_MUL, SRC_T2, SRC_T0, SRC_T0);       // t4
            5'd3:    u = mk(ALU_MUL, SRC_T3, SRC_TIME, SRC_CCRS);   // t*Pc
            5'd4:    u = mk(ALU_MUL, SRC_T4, SRC_TIME, SRC_VEL);
            5'd5:    u = mk(ALU_ADD, SRC_T4, SRC_POS, SRC_T4);
            5'd6:    u = mk(ALU_MUL, SRC_T5, SRC_T0, SRC_ACC);
            5'd7:    u = mk(ALU_MUL, SRC_T5, SRC_T5, SRC_HALF);
            5'd8:    u = mk(ALU_ADD, SRC_PPOS, SRC_T4, SRC_T5);
            5'd9:    u = mk(ALU_MUL, SRC_T4, SRC_TIME, SRC_ACC);
            5'd10:   u = mk(ALU_ADD, SRC_PVEL, SRC_VEL, SRC_T4);
            5'd11:   u = mk(ALU_ADD, SRC_T4, SRC_CPOS, SRC_T3);
            5'd12:   u = mk(ALU_ADD, SRC_T4, SRC_T4, SRC_T3);
            5'd13:   u = mk(ALU_MUL, SRC_T5, SRC_T0, SRC_CVEL);
            5'd14:   u = mk(ALU_ADD, SRC_T4, SRC_T4, SRC_T5);
            5'd15:   u = mk(ALU_MUL, SRC_T5, SRC_T2, SRC_QUARTER);
            5'd16:   u = mk(ALU_MUL, SRC_T5, SRC_T5, SRC_QN);
            5'd17:   u = mk(ALU_ADD, SRC_PCPOS, SRC_T4, SRC_T5);
            5'd18:   u = mk(ALU_MUL, SRC_T4, SRC_TIME, SRC_CVEL);
            5'd19:   u = mk(ALU_ADD, SRC_T4, SRC_CCRS, SRC_T4);
            5'd20:   u = mk(ALU_MUL, SRC_T5, SRC_T1, SRC_HALF);
            5'd21:   u = mk(ALU_MUL, SRC_T5, SRC_T5, SRC_QN);
            5'd22:   u = mk(ALU_ADD, SRC_PCCRS, SRC_T4, SRC_T5);
            5'd23:   u = mk(ALU_MUL, SRC_T4, SRC_T0, SRC_QN);
            5'd24:   u = mk(ALU_ADD, SRC_PCVEL, SRC_CVEL, SRC_T4);
            default: u = mk(ALU_ADD, SRC_T0, SRC_ZERO, SRC_ZERO);
        endcase
        return u;
    endfunction

    function automatic uop_t update_uop(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:    u = mk(ALU_ADD, SRC_T0, SRC_PCPOS, SRC_RN);    // s
            5'd1:    u = mk(ALU_DIV, SRC_T1, SRC_PCPOS, SRC_T0);    // kx
            5'd2:    u = mk(ALU_DIV, SRC_T2, SRC_PCCRS, SRC_T0);    // ky
            5'd3:    u = mk(ALU_SUB, SRC_T3, SRC_MEAS, SRC_PPOS);   // innovation
            5'd4:    u = mk(ALU_MUL, SRC_T4, SRC_T1, SRC_T3);
            5'd5:    u = mk(ALU_ADD, SRC_POS, SRC_PPOS, SRC_T4);
            5'd6:    u = mk(ALU_MUL, SRC_T4, SRC_T2, SRC_T3);
            5'd7:    u = mk(ALU_ADD, SRC_VEL, SRC_PVEL, SRC_T4);
            5'd8:    u = mk(ALU_SUB, SRC_T3, SRC_ONE, SRC_T1);      // m = 1 - kx
            5'd9:    u = mk(ALU_MUL, SRC_T4, SRC_T3, SRC_T3);
            5'd10:   u = mk(ALU_MUL, SRC_T4, SRC_T4, SRC_PCPOS);
            5'd11:   u = mk(ALU_MUL, SRC_T5, SRC_T1, SRC_T1);
            5'd12:   u = mk(ALU_MUL, SRC_T5, SRC_T5, SRC_RN);
            5'd13:   u = mk(ALU_ADD, SRC_CPOS, SRC_T4, SRC_T5);
            5'd14:   u = mk(ALU_MUL, SRC_T4, SRC_T2, SRC_PCPOS);
            5'd15:   u = mk(ALU_SUB, SRC_T4, SRC_PCCRS, SRC_T4);
            5'd16:   u = mk(ALU_MUL, SRC_T4, SRC_T3, SRC_T4);
            5'd17:   u = mk(ALU_MUL, SRC_T5, SRC_T1, SRC_T2);
            5'd18:   u = mk(ALU_MUL, SRC_T5, SRC_T5, SRC_RN);
            5'd19:   u = mk(ALU_ADD, SRC_CCRS, SRC_T4, SRC_T5);
            5'd20:   u = mk(ALU_MUL, SRC_T0, SRC_T2, SRC_T2);       // ky*ky
            5'd21:   u = mk(ALU_MUL, SRC_T1, SRC_T2, SRC_PCCRS);    // ky*Pc
            5'd22:   u = mk(ALU_MUL, SRC_T4, SRC_T0, SRC_PCPOS);
            5'd23:   u = mk(ALU_ADD, SRC_T5, SRC_T1, SRC_T1);
            5'd24:   u = mk(ALU_SUB, SRC_T4, SRC_T4, SRC_T5);
            5'd25:   u = mk(ALU_ADD, SRC_T4, SRC_T4, SRC_PCVEL);
            5'd26:   u = mk(ALU_MUL, SRC_T5, SRC_T0, SRC_RN);
            5'd27:   u = mk(ALU_ADD, SRC_CVEL, SRC_T4, SRC_T5);
            default: u = mk(ALU_ADD, SRC_T0, SRC_ZERO, SRC_ZERO);
        endcase
        return u;
    endfunction

    function automatic uop_t skip_uop(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:    u = mk(ALU_ADD, SRC_POS, SRC_PPOS, SRC_ZERO);
            5'd1:    u = mk(ALU_ADD, SRC_VEL, SRC_PVEL, SRC_ZERO);
            5'd2:    u = mk(ALU_ADD, SRC_CPOS, SRC_PCPOS, SRC_ZERO);
            5'd3:    u = mk(ALU_ADD, SRC_CCRS, SRC_PCCRS, SRC_ZERO);
            5'd4:    u = mk(ALU_ADD, SRC_CVEL, SRC_PCVEL, SRC_ZERO);
            default: u = mk(ALU_ADD, SRC_T0, SRC_ZERO, SRC_ZERO);
        endcase
        return u;
    endfunction

    function automatic uop_t prog_uop(input opcode_t opc, input logic [PC_W-1:0] pc);
        uop_t u;
        case (opc)
            OPC_PREDICT: u = predict_uop(pc);
            OPC_UPDATE:  u = update_uop(pc);
            default:     u = skip_uop(pc);
        endcase
        return u;
    endfunction

    function automatic logic [PC_W-1:0] prog_len(input opcode_t opc);
        logic [PC_W-1:0] n;
        case (opc)
            OPC_PREDICT: n = 5'd25;
            OPC_UPDATE:  n = 5'd28;
            OPC_SKIP:    n = 5'd5;
            default:     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

@@ src/kfpv_intf.sv @@
// Item and result channel interfaces.
`default_nettype none
interface kfpv_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [31:0]        time_step;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    modport source (output valid, opcode, time_step, accel_x, accel_y, accel_z,
                    meas_x, meas_y, meas_z, input ready);
    modport sink (input valid, opcode, time_step, accel_x, accel_y, accel_z,
                  meas_x, meas_y, meas_z, output ready);
endinterface

interface kfpv_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    modport source (output valid, out_pos_x, out_pos_y, out_pos_z,
                    out_vel_x, out_vel_y, out_vel_z, input ready);
    modport sink (input valid, out_pos_x, out_pos_y, out_pos_z,
                  out_vel_x, out_vel_y, out_vel_z, output ready);
endinterface
`default_nettype wire

@@ src/kalman_filter_pos_vel_3axis_core.sv @@
// Top level: three-axis constant-velocity Kalman filter core.
//
//  channel  | dir | handshake        | beat contents
//  ---------+-----+------------------+--------------------------------------------
//  item     | in  | valid/ready      | opcode, time_step, accel_x/y/z, meas_x/y/z
//  result   | out | valid/ready      | out_pos_x/y/z, out_vel_x/y/z
//  apb      | in  | psel/penable     | eight 32-bit registers at 4*i, pready tied high
//
// One item at a time. Each axis: load its ten state words, run the opcode's
// microprogram on the shared ALU (a divide by a non-positive divisor returns zero
// without iterating), then write the ten words back. Opcode 3 runs no microprogram
// and goes straight from load to write-back.
// Reset is asynchronous; valid bits make unwritten state words read as reset values.
// A new item is taken while a result waits; DONE stalls only if that result is held.
`default_nettype none
`include "kalman_filter_pos_vel_3axis_core_defines.svh"
module kalman_filter_pos_vel_3axis_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    kfpv_item_if.sink                          item,
    kfpv_result_if.source                      result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kfpv_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    // configuration
    logic [31:0]         cfg_val [kfpv_pkg::NREG];
    kfpv_pkg::cfg_evt_t  cfg_evt;

    // sequencer
    kfpv_pkg::seq_state_t state_reg, state_next;
    logic [kfpv_pkg::AXIS_W-1:0]  axis_reg;
    logic [kfpv_pkg::FIELD_W-1:0] fcnt_reg;
    logic [kfpv_pkg::PC_W-1:0]    pc_reg;
    kfpv_pkg::opcode_t            opc_reg;
    kfpv_pkg::uop_t               uop;
    logic [kfpv_pkg::PC_W-1:0]    plen;

    // captured item
    kfpv_pkg::q_t time_reg;
    kfpv_pkg::q_t accel_reg [3];
    kfpv_pkg::q_t meas_reg  [3];

    // working slots, operand latches, write-back staging
    kfpv_pkg::q_t slot_reg [kfpv_pkg::NSLOT];
    kfpv_pkg::q_t opa_reg, opb_reg, wb_reg;
    kfpv_pkg::q_t q_cur, r_cur, opa_sel, opb_sel;
    logic [kfpv_pkg::REG_IDX_W-1:0] q_idx, r_idx;

    // per-axis results and the output register
    kfpv_pkg::q_t pos_res_reg [3];
    kfpv_pkg::q_t vel_res_reg [3];
    kfpv_pkg::q_t out_pos_reg [3];
    kfpv_pkg::q_t out_vel_reg [3];
    logic         result_valid_reg;

    // memory and ALU hookup
    logic                              mem_rd_en, mem_wr_en;
    logic [kfpv_pkg::MEM_ADDR_W-1:0]   mem_rd_addr, mem_wr_addr;
    kfpv_pkg::q_t                      mem_rd_value;
    logic                              alu_start, alu_done;
    kfpv_pkg::q_t                      alu_result;
    logic                              accept, last_axis, load_done;

    kfpv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_val (cfg_val),
        .cfg_evt (cfg_evt)
    );

    kfpv_smem u_smem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (wb_reg),
        .cfg_evt  (cfg_evt),
        .init_pos (kfpv_pkg::clamp_u(cfg_val[kfpv_pkg::REG_INIT_POS])),
        .init_vel (kfpv_pkg::clamp_u(cfg_val[kfpv_pkg::REG_INIT_VEL])),
        .rd_value (mem_rd_value)
    );

    kfpv_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (uop.op),
        .a      (opa_reg),
        .b      (opb_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    function automatic kfpv_pkg::q_t pick(input kfpv_pkg::src_t c);
        kfpv_pkg::q_t v;
        case (c)
            kfpv_pkg::SRC_TIME:    v = time_reg;
            kfpv_pkg::SRC_ACC:     v = accel_reg[axis_reg];
            kfpv_pkg::SRC_MEAS:    v = meas_reg[axis_reg];
            kfpv_pkg::SRC_QN:      v = q_cur;
            kfpv_pkg::SRC_RN:      v = r_cur;
            kfpv_pkg::SRC_ONE:     v = kfpv_pkg::Q_ONE;
            kfpv_pkg::SRC_HALF:    v = kfpv_pkg::Q_HALF;
            kfpv_pkg::SRC_QUARTER: v = kfpv_pkg::Q_QUARTER;
            kfpv_pkg::SRC_ZERO:    v = kfpv_pkg::Q_ZERO;
            default:               v = slot_reg[c[kfpv_pkg::SLOT_W-1:0]];
        endcase
        return v;
    endfunction

    always_comb
    begin
        accept    = item.valid && item.ready;
        uop       = kfpv_pkg::prog_uop(opc_reg, pc_reg);
        plen      = kfpv_pkg::prog_len(opc_reg);
        q_idx     = kfpv_pkg::REG_Q0 + kfpv_pkg::REG_IDX_W'(axis_reg);
        r_idx     = kfpv_pkg::REG_R0 + kfpv_pkg::REG_IDX_W'(axis_reg);
        q_cur     = kfpv_pkg::clamp_u(cfg_val[q_idx]);
        r_cur     = kfpv_pkg::clamp_u(cfg_val[r_idx]);
        opa_sel   = pick(uop.a);
        opb_sel   = pick(uop.b);
        last_axis = (axis_reg == kfpv_pkg::AXIS_W'(kfpv_pkg::AXES - 1));
        load_done = (fcnt_reg == kfpv_pkg::FIELD_W'(kfpv_pkg::NFIELD));

        mem_rd_addr = {fcnt_reg, axis_reg};
        mem_wr_addr = {fcnt_reg - 1'b1, axis_reg};
    end

    // sequencer: load axis state, run microprogram, write back, next axis
    always_comb
    begin
        state_next = state_reg;
        item.ready = (state_reg == kfpv_pkg::SEQ_IDLE);
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        alu_start  = 1'b0;
        case (state_reg)
            kfpv_pkg::SEQ_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = kfpv_pkg::SEQ_LOAD;
                end
            end
            kfpv_pkg::SEQ_LOAD:
            begin
                mem_rd_en = !load_done;
                if (load_done)
                begin
                    state_next = (plen == '0) ? kfpv_pkg::SEQ_WB : kfpv_pkg::SEQ_OPRD;
                end
            end
            kfpv_pkg::SEQ_OPRD:  state_next = kfpv_pkg::SEQ_ISSUE;
            kfpv_pkg::SEQ_ISSUE:
            begin
                alu_start  = 1'b1;
                state_next = kfpv_pkg::SEQ_WAIT;
            end
            kfpv_pkg::SEQ_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = (pc_reg == plen - 1'b1) ? kfpv_pkg::SEQ_WB : kfpv_pkg::SEQ_OPRD;
                end
            end
            kfpv_pkg::SEQ_WB:
            begin
                mem_wr_en = (fcnt_reg != '0);
                if (load_done)
                begin
                    state_next = last_axis ? kfpv_pkg::SEQ_DONE : kfpv_pkg::SEQ_LOAD;
                end
            end
            kfpv_pkg::SEQ_DONE:
            begin
                if (!result_valid_reg || result.ready)
                begin
                    state_next = kfpv_pkg::SEQ_IDLE;
                end
            end
            default: state_next = kfpv_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kfpv_pkg::SEQ_IDLE;
            axis_reg         <= '0;
            fcnt_reg         <= '0;
            pc_reg           <= '0;
            opc_reg          <= kfpv_pkg::OPC_NOP;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == kfpv_pkg::SEQ_DONE && state_next == kfpv_pkg::SEQ_IDLE)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                kfpv_pkg::SEQ_IDLE:
                begin
                    if (accept)
                    begin
                        opc_reg  <= kfpv_pkg::opcode_t'(item.opcode);
                        axis_reg <= '0;
                        fcnt_reg <= '0;
                    end
                end
                kfpv_pkg::SEQ_LOAD:
                begin
                    fcnt_reg <= load_done ? '0 : fcnt_reg + 1'b1;
                    pc_reg   <= '0;
                end
                kfpv_pkg::SEQ_WAIT:
                begin
                    if (alu_done)
                    begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
                kfpv_pkg::SEQ_WB:
                begin
                    fcnt_reg <= load_done ? '0 : fcnt_reg + 1'b1;
                    if (load_done)
                    begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                default: pc_reg <= pc_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg     <= kfpv_pkg::clamp_u(item.time_step);
            accel_reg[0] <= item.accel_x;
            accel_reg[1] <= item.accel_y;
            accel_reg[2] <= item.accel_z;
            meas_reg[0]  <= item.meas_x;
            meas_reg[1]  <= item.meas_y;
            meas_reg[2]  <= item.meas_z;
            for (int i = 0; i < 3; i++)
            begin
                pos_res_reg[i] <= kfpv_pkg::Q_ZERO;
                vel_res_reg[i] <= kfpv_pkg::Q_ZERO;
            end
        end
        // memory data lands in the cycle after its read
        if (state_reg == kfpv_pkg::SEQ_LOAD && fcnt_reg != '0)
        begin
            slot_reg[fcnt_reg - 1'b1] <= mem_rd_value;
        end
        if (state_reg == kfpv_pkg::SEQ_OPRD)
        begin
            opa_reg <= opa_sel;
            opb_reg <= opb_sel;
        end
        if (state_reg == kfpv_pkg::SEQ_WAIT && alu_done)
        begin
            slot_reg[uop.dst[kfpv_pkg::SLOT_W-1:0]] <= alu_result;
        end
        if (state_reg == kfpv_pkg::SEQ_WB)
        begin
            if (!load_done)
            begin
                wb_reg <= slot_reg[fcnt_reg];
            end
            else
            begin
                pos_res_reg[axis_reg] <= slot_reg[kfpv_pkg::F_POS];
                vel_res_reg[axis_reg] <= slot_reg[kfpv_pkg::F_VEL];
            end
        end
        if (state_reg == kfpv_pkg::SEQ_DONE && state_next == kfpv_pkg::SEQ_IDLE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_pos_reg[i] <= pos_res_reg[i];
                out_vel_reg[i] <= vel_res_reg[i];
            end
        end
    end

    assign result.valid     = result_valid_reg;
    assign result.out_pos_x = out_pos_reg[0];
    assign result.out_pos_y = out_pos_reg[1];
    assign result.out_pos_z = out_pos_reg[2];
    assign result.out_vel_x = out_vel_reg[0];
    assign result.out_vel_y = out_vel_reg[1];
    assign result.out_vel_z = out_vel_reg[2];

    // an accepted item starts its first axis load from field zero
    `KFPV_ASSERT_NEXT(a_accept_load, accept,
        state_reg == kfpv_pkg::SEQ_LOAD && fcnt_reg == '0 && axis_reg == '0)
    // ALU completion is only ever seen while the sequencer waits for it
    `KFPV_ASSERT_IMPLY(a_alu_done_wait, alu_done, state_reg == kfpv_pkg::SEQ_WAIT)
    // a new result appears only as the sequencer leaves DONE
    `KFPV_ASSERT_IMPLY(a_result_from_done, $rose(result_valid_reg), $past(state_reg == kfpv_pkg::SEQ_DONE))
endmodule
`default_nettype wire

@@ src/kfpv_regs.sv @@
// APB configuration registers.
`default_nettype none
module kfpv_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [kfpv_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    output logic [31:0]                           cfg_val [kfpv_pkg::NREG],
    output kfpv_pkg::cfg_evt_t                    cfg_evt
);
    logic [31:0] regs_reg [kfpv_pkg::NREG];
    logic [kfpv_pkg::REG_IDX_W-1:0] idx;
    logic wr;

    assign idx    = paddr[kfpv_pkg::PADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kfpv_pkg::NREG; i++)
            begin
                regs_reg[i] <= kfpv_pkg::REG_RESET;
            end
        end
        else if (wr)
        begin
            regs_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata          = regs_reg[idx];
        cfg_evt.pos_var = wr && (idx == kfpv_pkg::REG_INIT_POS);
        cfg_evt.vel_var = wr && (idx == kfpv_pkg::REG_INIT_VEL);
        for (int i = 0; i < kfpv_pkg::NREG; i++)
        begin
            cfg_val[i] = regs_reg[i];
        end
    end
endmodule
`default_nettype wire

@@ src/kfpv_smem.sv @@
// State memory: per-axis filter state, with valid bits standing in for reset values.
`default_nettype none
module kfpv_smem (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rd_en,
    input  wire logic [kfpv_pkg::MEM_ADDR_W-1:0]   rd_addr,
    input  wire logic                              wr_en,
    input  wire logic [kfpv_pkg::MEM_ADDR_W-1:0]   wr_addr,
    input  wire kfpv_pkg::q_t                      wr_data,
    input  wire kfpv_pkg::cfg_evt_t                cfg_evt,
    input  wire kfpv_pkg::q_t                      init_pos,
    input  wire kfpv_pkg::q_t                      init_vel,
    output kfpv_pkg::q_t                           rd_value
);
    kfpv_pkg::q_t mem [kfpv_pkg::MEM_DEPTH];
    logic [kfpv_pkg::MEM_DEPTH-1:0] valid_reg;
    kfpv_pkg::q_t     rd_data_reg;
    logic             rd_valid_reg;
    kfpv_pkg::field_t rd_field_reg;
    kfpv_pkg::q_t     reset_value;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_field_reg <= kfpv_pkg::field_t'(rd_addr[kfpv_pkg::MEM_ADDR_W-1 -: kfpv_pkg::FIELD_W]);
        end
    end

    // an entry not yet written reads as its reset value; a variance reload re-arms its covariance entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            for (int ax = 0; ax < kfpv_pkg::AXES; ax++)
            begin
                if (cfg_evt.pos_var)
                begin
                    valid_reg[{kfpv_pkg::F_CPOS, kfpv_pkg::AXIS_W'(ax)}]  <= 1'b0;
                    valid_reg[{kfpv_pkg::F_PCPOS, kfpv_pkg::AXIS_W'(ax)}] <= 1'b0;
                end
                if (cfg_evt.vel_var)
                begin
                    valid_reg[{kfpv_pkg::F_CVEL, kfpv_pkg::AXIS_W'(ax)}]  <= 1'b0;
                    valid_reg[{kfpv_pkg::F_PCVEL, kfpv_pkg::AXIS_W'(ax)}] <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        case (rd_field_reg)
            kfpv_pkg::F_CPOS, kfpv_pkg::F_PCPOS: reset_value = init_pos;
            kfpv_pkg::F_CVEL, kfpv_pkg::F_PCVEL: reset_value = init_vel;
            default:                             reset_value = kfpv_pkg::Q_ZERO;
        endcase
        rd_value = rd_valid_reg ? rd_data_reg : reset_value;
    end
endmodule
`default_nettype wire

@@ src/kfpv_alu.sv @@
// Shared arithmetic unit: saturating add/sub, rounded Q multiply, iterative Q divide.
`default_nettype none
module kfpv_alu (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire kfpv_pkg::alu_op_t  op,
    input  wire kfpv_pkg::q_t       a,
    input  wire kfpv_pkg::q_t       b,
    output logic                    done,
    output kfpv_pkg::q_t            result
);
    kfpv_pkg::alu_state_t state_reg, state_next;
    logic                 done_reg;
    kfpv_pkg::q_t         result_reg;
    logic signed [2*kfpv_pkg::DATA_W-1:0] prod_reg;
    logic [kfpv_pkg::DIVD_W-1:0]   quo_reg;
    logic [kfpv_pkg::DATA_W-1:0]   rem_reg;
    logic [kfpv_pkg::DATA_W-1:0]   div_reg;
    logic                          neg_reg;
    logic [kfpv_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic signed [kfpv_pkg::DATA_W:0]     sum;
    logic signed [2*kfpv_pkg::DATA_W-1:0] rnd;
    logic [kfpv_pkg::DATA_W-1:0]          mag;
    logic [kfpv_pkg::DATA_W-1:0]          trial;
    logic                                 fits;
    kfpv_pkg::q_t                         sum_sat, mul_sat, div_sat;

    always_comb
    begin
        sum = (op == kfpv_pkg::ALU_SUB) ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        if (sum[kfpv_pkg::DATA_W] != sum[kfpv_pkg::DATA_W-1])
        begin
            sum_sat = sum[kfpv_pkg::DATA_W] ? kfpv_pkg::Q_MIN : kfpv_pkg::Q_MAX;
        end
        else
        begin
            sum_sat = kfpv_pkg::q_t'(sum[kfpv_pkg::DATA_W-1:0]);
        end

        // round half up then floor shift
        rnd = (prod_reg + (64'sd1 <<< (kfpv_pkg::FRAC_BITS - 1))) >>> kfpv_pkg::FRAC_BITS;
        if (rnd > 64'sd2147483647)
        begin
            mul_sat = kfpv_pkg::Q_MAX;
        end
        else if (rnd < -64'sd2147483648)
        begin
            mul_sat = kfpv_pkg::Q_MIN;
        end
        else
        begin
            mul_sat = kfpv_pkg::q_t'(rnd[kfpv_pkg::DATA_W-1:0]);
        end

        mag   = a[kfpv_pkg::DATA_W-1] ? (32'd0 - a) : a;
        trial = {rem_reg[kfpv_pkg::DATA_W-2:0], quo_reg[kfpv_pkg::DIVD_W-1]};

        // quotient magnitude to signed with saturation
        if (neg_reg)
        begin
            fits    = (quo_reg <= kfpv_pkg::DIVD_W'(33'h1_0000_0000 >> 1));
            div_sat = fits ? kfpv_pkg::q_t'(32'd0 - quo_reg[kfpv_pkg::DATA_W-1:0])
                           : kfpv_pkg::Q_MIN;
        end
        else
        begin
            fits    = (quo_reg <= kfpv_pkg::DIVD_W'(32'h7FFF_FFFF));
            div_sat = fits ? kfpv_pkg::q_t'(quo_reg[kfpv_pkg::DATA_W-1:0]) : kfpv_pkg::Q_MAX;
        end

        state_next = state_reg;
        case (state_reg)
            kfpv_pkg::A_IDLE:
            begin
                if (start && op == kfpv_pkg::ALU_MUL)
                begin
                    state_next = kfpv_pkg::A_MULRND;
                end
                else if (start && op == kfpv_pkg::ALU_DIV && b > kfpv_pkg::Q_ZERO)
                begin
                    state_next = kfpv_pkg::A_DIVRUN;
                end
            end
            kfpv_pkg::A_MULRND: state_next = kfpv_pkg::A_IDLE;
            kfpv_pkg::A_DIVRUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = kfpv_pkg::A_DIVFIN;
                end
            end
            kfpv_pkg::A_DIVFIN: state_next = kfpv_pkg::A_IDLE;
            default:            state_next = kfpv_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kfpv_pkg::A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            case (state_reg)
                kfpv_pkg::A_IDLE:
                begin
                    if (start && (op == kfpv_pkg::ALU_ADD || op == kfpv_pkg::ALU_SUB ||
                                  (op == kfpv_pkg::ALU_DIV && b <= kfpv_pkg::Q_ZERO)))
                    begin
                        done_reg <= 1'b1;
                    end
                end
                kfpv_pkg::A_MULRND: done_reg <= 1'b1;
                kfpv_pkg::A_DIVFIN: done_reg <= 1'b1;
                default:            done_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            kfpv_pkg::A_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        kfpv_pkg::ALU_MUL: prod_reg <= a * b;
                        kfpv_pkg::ALU_DIV:
                        begin
                            result_reg <= kfpv_pkg::Q_ZERO;
                            neg_reg    <= a[kfpv_pkg::DATA_W-1];
                            quo_reg    <= {mag, kfpv_pkg::FRAC_BITS'(0)};
                            rem_reg    <= '0;
                            div_reg    <= b;
                            cnt_reg    <= kfpv_pkg::DIV_CNT_W'(kfpv_pkg::DIVD_W - 1);
                        end
                        default: result_reg <= sum_sat;
                    endcase
                end
            end
            kfpv_pkg::A_MULRND: result_reg <= mul_sat;
            kfpv_pkg::A_DIVRUN:
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (trial >= div_reg)
                begin
                    rem_reg <= trial - div_reg;
                    quo_reg <= {quo_reg[kfpv_pkg::DIVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[kfpv_pkg::DIVD_W-2:0], 1'b0};
                end
            end
            kfpv_pkg::A_DIVFIN: result_reg <= div_sat;
            default:            result_reg <= result_reg;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

@@ tb/sv/kalman_filter_pos_vel_3axis_core_test.sv @@
// Testbench for the three-axis Kalman filter core: directed and random beats.
`timescale 1ns / 100ps
`default_nettype none
module kalman_filter_pos_vel_3axis_core_test;
    import kfpv_pkg::*;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
    } track_t;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int     IDLE_PCT = 27;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    kfpv_item_if   item_ch ();
    kfpv_result_if res_ch ();

    kalman_filter_pos_vel_3axis_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch.sink),
        .result  (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Filter mirror: registers plus current and predicted state per axis.
    logic [31:0] noise_reg [NREG];
    longint est_pos [3], est_vel [3], fc_pos [3], fc_vel [3];
    longint cov_a [3], cov_c [3], cov_v [3];
    longint fcov_a [3], fcov_c [3], fcov_v [3];

    track_t track_q [$];
    int     errors;
    bit     idle_on;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Fixed-point helpers (Q16.16, saturating)
    // ---------------------------------------------------------------
    function automatic longint sat32(input longint x);
        if (x > SMAX) return SMAX;
        if (x < SMIN) return SMIN;
        return x;
    endfunction

    function automatic longint from_unsigned(input logic [31:0] v);
        return v[31] ? SMAX : longint'(v);
    endfunction

    function automatic longint qadd(input longint a, input longint b);
        return sat32(a + b);
    endfunction

    function automatic longint qsub(input longint a, input longint b);
        return sat32(a - b);
    endfunction

    // round half up, floor shift
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        return sat32(p >>> FRAC_BITS);
    endfunction

    // zero gain when the denominator is not positive
    function automatic longint qdiv(input longint n, input longint s);
        if (s <= 0) return 0;
        return sat32((n * (64'sd1 <<< FRAC_BITS)) / s);
    endfunction

    task automatic reload_pos_var();
        for (int i = 0; i < AXES; i++) begin
            cov_a[i]  = from_unsigned(noise_reg[REG_INIT_POS]);
            fcov_a[i] = cov_a[i];
        end
    endtask

    task automatic reload_vel_var();
        for (int i = 0; i < AXES; i++) begin
            cov_v[i]  = from_unsigned(noise_reg[REG_INIT_VEL]);
            fcov_v[i] = cov_v[i];
        end
    endtask

    task automatic mirror_reset();
        for (int i = 0; i < NREG; i++) noise_reg[i] = REG_RESET;
        for (int i = 0; i < 3; i++) begin
            est_pos[i] = 0; est_vel[i] = 0; fc_pos[i] = 0; fc_vel[i] = 0;
            cov_a[i] = 0; cov_c[i] = 0; cov_v[i] = 0;
            fcov_a[i] = 0; fcov_c[i] = 0; fcov_v[i] = 0;
        end
        reload_pos_var();
        reload_vel_var();
    endtask

    task automatic predict_axis(input int i, input longint t, input longint a);
        longint q, t2, t3, t4, pa, pc, pv, tc;
        q  = from_unsigned(noise_reg[int'(REG_Q0) + i]);
        t2 = qmul(t, t);
        t3 = qmul(t2, t);
        t4 = qmul(t2, t2);
        pa = cov_a[i]; pc = cov_c[i]; pv = cov_v[i];
        tc = qmul(t, pc);
        fc_pos[i] = qadd(qadd(est_pos[i], qmul(t, est_vel[i])), qmul(qmul(t2, a), Q_HALF));
        fc_vel[i] = qadd(est_vel[i], qmul(t, a));
        fcov_a[i] = qadd(qadd(qadd(qadd(pa, tc), tc), qmul(t2, pv)),
                         qmul(qmul(t4, Q_QUARTER), q));
        fcov_c[i] = qadd(qadd(pc, qmul(t, pv)), qmul(qmul(t3, Q_HALF), q));
        fcov_v[i] = qadd(pv, qmul(t2, q));
    endtask

    // Joseph-form update; velocity uses the position innovation
    task automatic update_axis(input int i, input longint z);
        longint r, pa, pc, pv, s, kx, ky, e, m, kk, kc;
        r  = from_unsigned(noise_reg[int'(REG_R0) + i]);
        pa = fcov_a[i]; pc = fcov_c[i]; pv = fcov_v[i];
        s  = qadd(pa, r);
        kx = qdiv(pa, s);
        ky = qdiv(pc, s);
        e  = qsub(z, fc_pos[i]);
        m  = qsub(Q_ONE, kx);
        kk = qmul(ky, ky);
        kc = qmul(ky, pc);
        est_pos[i] = qadd(fc_pos[i], qmul(kx, e));
        est_vel[i] = qadd(fc_vel[i], qmul(ky, e));
        cov_a[i] = qadd(qmul(qmul(m, m), pa), qmul(qmul(kx, kx), r));
        cov_c[i] = qadd(qmul(m, qsub(pc, qmul(ky, pa))), qmul(qmul(kx, ky), r));
        cov_v[i] = qadd(qadd(qsub(qmul(kk, pa), qadd(kc, kc)), pv), qmul(kk, r));
    endtask

    task automatic filter_step(input opcode_t op, input logic [31:0] ts,
                               input logic signed [31:0] acc [3],
                               input logic signed [31:0] meas [3]);
        track_t exp_t;
        for (int i = 0; i < AXES; i++) begin
            case (op)
                OPC_PREDICT: predict_axis(i, from_unsigned(ts), longint'(acc[i]));
                OPC_UPDATE:  update_axis(i, longint'(meas[i]));
                OPC_SKIP:
                begin
                    est_pos[i] = fc_pos[i]; est_vel[i] = fc_vel[i];
                    cov_a[i] = fcov_a[i]; cov_c[i] = fcov_c[i]; cov_v[i] = fcov_v[i];
                end
                default: ;
            endcase
        end
        for (int i = 0; i < 3; i++) begin
            exp_t.pos[i] = est_pos[i][31:0];
            exp_t.vel[i] = est_vel[i][31:0];
        end
        track_q.push_back(exp_t);
    endtask

    // ---------------------------------------------------------------
    // Bus drivers
    // ---------------------------------------------------------------
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);       // register takes the value on this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        noise_reg[idx] = val;
        if (idx == REG_INIT_POS) reload_pos_var();
        if (idx == REG_INIT_VEL) reload_vel_var();
        @(posedge clk);
    endtask

    // Called at a rising edge; returns at the edge that accepted the beat.
    task automatic send_item(input opcode_t op, input logic [31:0] ts,
                             input logic signed [31:0] acc [3],
                             input logic signed [31:0] meas [3]);
        bit took;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.time_step <= ts;
        item_ch.accel_x   <= acc[0];
        item_ch.accel_y   <= acc[1];
        item_ch.accel_z   <= acc[2];
        item_ch.meas_x    <= meas[0];
        item_ch.meas_y    <= meas[1];
        item_ch.meas_z    <= meas[2];
        do
        begin
            @(negedge clk);
            took = item_ch.ready;
            @(posedge clk);
        end
        while (!took);
        filter_step(op, ts, acc, meas);
    endtask

    // Let the core drain, then give it margin before touching registers.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (track_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Result checker: sample mid-cycle, act on the following edge
    // ---------------------------------------------------------------
    initial
    begin
        bit     take;
        track_t got, want;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            take = res_ch.valid && res_ch.ready;
            got.pos[0] = res_ch.out_pos_x; got.pos[1] = res_ch.out_pos_y;
            got.pos[2] = res_ch.out_pos_z;
            got.vel[0] = res_ch.out_vel_x; got.vel[1] = res_ch.out_vel_y;
            got.vel[2] = res_ch.out_vel_z;
            @(posedge clk);
            if (take)
            begin
                if (track_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = track_q.pop_front();
                    for (int i = 0; i < 3; i++)
                    begin
                        if (got.pos[i] !== want.pos[i])
                        begin
                            $display("%0t: pos[%0d] expected %h actual %h",
                                     $time, i, want.pos[i], got.pos[i]);
                            errors++;
                        end
                        if (got.vel[i] !== want.vel[i])
                        begin
                            $display("%0t: vel[%0d] expected %h actual %h",
                                     $time, i, want.vel[i], got.vel[i]);
                            errors++;
                        end
                    end
                end
            end
            res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // Plausible tracking beat: modest dt, accel and positions near the track.
    task automatic send_plausible(input opcode_t op);
        logic signed [31:0] acc [3], meas [3];
        logic [31:0] ts;
        ts = $urandom_range(32'h0002_0000);
        for (int i = 0; i < 3; i++) begin
            acc[i]  = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            meas[i] = est_pos[i][31:0] + ($signed($urandom_range(32'h0010_0000))
                      - 32'sh0008_0000);
        end
        send_item(op, ts, acc, meas);
    endtask

    task automatic send_noise();
        logic signed [31:0] acc [3], meas [3];
        for (int i = 0; i < 3; i++) begin
            acc[i]  = rand_word();
            meas[i] = rand_word();
        end
        send_item(opcode_t'($urandom_range(3)), rand_word(), acc, meas);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Every opcode from reset, including the unused one.
    task automatic test_each_opcode();
        send_plausible(OPC_NOP);
        send_plausible(OPC_PREDICT);
        send_plausible(OPC_SKIP);
        send_plausible(OPC_PREDICT);
        send_plausible(OPC_UPDATE);
        send_plausible(OPC_NOP);
    endtask

    // Field extremes: saturation of time, accel and measurement.
    task automatic test_extremes();
        logic signed [31:0] hi [3], lo [3], zz [3];
        for (int i = 0; i < 3; i++) begin
            hi[i] = 32'sh7FFF_FFFF; lo[i] = 32'sh8000_0000; zz[i] = 0;
        end
        send_item(OPC_PREDICT, 32'hFFFF_FFFF, hi, lo);
        send_item(OPC_UPDATE, 32'h0, zz, hi);
        send_item(OPC_PREDICT, 32'h7FFF_FFFF, lo, hi);
        send_item(OPC_UPDATE, 32'hFFFF_FFFF, hi, lo);
        send_item(OPC_PREDICT, 32'h0, zz, zz);
        send_item(OPC_SKIP, 32'h8000_0000, hi, hi);
        send_item(OPC_PREDICT, 32'h0001_0000, hi, zz);
        send_item(OPC_UPDATE, 32'h0, zz, zz);
    endtask

    // Zero variances give a zero denominator, so the gains drop to zero.
    task automatic test_zero_gain();
        drain();
        reg_write(REG_INIT_POS, 32'h0);
        for (int i = 0; i < 3; i++) reg_write(REG_R0 + 3'(i), 32'h0);
        reg_write(REG_Q0, 32'h0);
        send_plausible(OPC_UPDATE);
        send_plausible(OPC_PREDICT);
        send_plausible(OPC_UPDATE);
        send_plausible(OPC_SKIP);
    endtask

    // Random run, split into phases with a fresh register setting each.
    task automatic test_random(input int n_items);
        int phase_len;
        phase_len = n_items / 8;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % phase_len == 0)
            begin
                // sender holds off until everything is back, then reprograms
                drain();
                for (int r = 0; r < NREG; r++)
                begin
                    logic [31:0] v;
                    case ((k / phase_len + r) % 4)
                        0:       v = 32'h0;
                        1:       v = 32'hFFFF_FFFF;
                        2:       v = $urandom_range(32'h0004_0000);
                        default: v = rand_word();
                    endcase
                    reg_write(REG_IDX_W'(r), v);
                end
            end
            // one stretch with no idling on either side
            idle_on = !(k >= n_items / 2 && k < n_items / 2 + 150);
            if ($urandom_range(99) < 15) send_noise();
            else
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: send_plausible(OPC_PREDICT);
                    4, 5, 6, 7: send_plausible(OPC_UPDATE);
                    8:          send_plausible(OPC_SKIP);
                    default:    send_plausible(OPC_NOP);
                endcase
            end
        end
        idle_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        errors        = 0;
        idle_on       = 1'b1;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_ch.valid = 1'b0;
        item_ch.opcode    = OPC_NOP;
        item_ch.time_step = '0;
        item_ch.accel_x = '0; item_ch.accel_y = '0; item_ch.accel_z = '0;
        item_ch.meas_x  = '0; item_ch.meas_y  = '0; item_ch.meas_z  = '0;
        mirror_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_opcode();
        test_extremes();
        test_zero_gain();
        test_random(920);

        drain();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: well above the slowest legal run
    initial
    begin
        #60_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
